[design/rgb_to_cielab_converter_defines.svh]
// Assertion macros shared by the converter RTL.
`ifndef RGB_TO_CIELAB_CONVERTER_DEFINES_SVH
`define RGB_TO_CIELAB_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define RGB2LAB_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");
`define RGB2LAB_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define RGB2LAB_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define RGB2LAB_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

[design/rgb2lab_pkg.sv]
package rgb2lab_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_CH      = 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [10:0]            light_t;
  typedef logic signed [11:0]     axis_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHITE_RED   = 2'd0,
    CFG_WHITE_GREEN = 2'd1,
    CFG_WHITE_BLUE  = 2'd2
  } cfg_idx_e;

  localparam sample_t WHITE_RESET = SAMPLE_BITS'(1023);

  // Channel ratio: Q24 quotient built two bits per stage.
  localparam int QUO_W          = 24;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
  localparam int RATIO_W        = QUO_W + 1;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << QUO_W;

  // Matrix scaled by 10000, rows X, Y, Z.
  localparam int COEF_W = 14;
  localparam int PROD_W = RATIO_W + COEF_W;
  localparam logic [COEF_W-1:0] MATRIX [NUM_CH][NUM_CH] = '{
    '{14'd4124, 14'd3576, 14'd1805},
    '{14'd2126, 14'd7152, 14'd722},
    '{14'd193,  14'd1192, 14'd9505}
  };
  localparam logic [3:0]  T_MUL [NUM_CH] = '{4'd10, 4'd1, 4'd10};
  localparam logic [16:0] T_ADD [NUM_CH] = '{17'd47522, 17'd5000, 17'd54446};

  // Constant dividers: lanes 0..2 give t for X, Y, Z, lanes 3..5 the linear f branch.
  localparam int CD_LANES = 2 * NUM_CH;
  localparam int CD_N_W   = 41;
  localparam int CD_SPLIT = 21;
  localparam int CD_HI_W  = CD_N_W - CD_SPLIT;
  localparam int RECIP_W  = 28;
  localparam int DIVR_W   = 17;
  localparam int CD_Q_W   = 26;
  localparam int CD_QD_W  = CD_Q_W + DIVR_W;
  localparam logic [DIVR_W-1:0] CD_DIVISOR [CD_LANES] = '{
    17'd95045, 17'd10000, 17'd108892, 17'd50112, 17'd50112, 17'd50112
  };
  localparam logic [RECIP_W-1:0] CD_RECIP [CD_LANES] = '{
    RECIP_W'((64'd1 << CD_N_W) / 64'd95045),
    RECIP_W'((64'd1 << CD_N_W) / 64'd10000),
    RECIP_W'((64'd1 << CD_N_W) / 64'd108892),
    RECIP_W'((64'd1 << CD_N_W) / 64'd50112),
    RECIP_W'((64'd1 << CD_N_W) / 64'd50112),
    RECIP_W'((64'd1 << CD_N_W) / 64'd50112)
  };

  // Lab f-function.
  localparam int T_W        = 25;
  localparam int F_W        = 21;
  localparam int CUBE_STEPS = F_W;
  localparam int CUBE_SHIFT = 36;
  localparam logic [14:0]       LIN_MUL    = 15'd24389;
  localparam logic [CD_N_W-1:0] LIN_ADD    = CD_N_W'((64'd6912 << 20) + 64'd25056);
  localparam logic [CD_N_W-1:0] CUBE_LIMIT = CD_N_W'(64'd216 << 24);
  localparam logic [F_W-1:0]    LIN_F_MAX  = F_W'(262144);

  // Pipeline layout.
  localparam int CD_STAGES  = 4;
  localparam int LIN_DEPTH  = CUBE_STEPS - 1 - CD_STAGES;
  localparam int PIPE_DEPTH = DIV_STAGES + 2 + CD_STAGES + CUBE_STEPS + 1;

endpackage

[design/rgb2lab_if.sv]
interface rgb2lab_pix_if;
  import rgb2lab_pkg::*;
  logic    valid;
  logic    ready;
  sample_t red_raw;
  sample_t green_raw;
  sample_t blue_raw;
  modport source (output valid, output red_raw, output green_raw, output blue_raw,
                  input ready);
  modport sink (input valid, input red_raw, input green_raw, input blue_raw,
                output ready);
endinterface

interface rgb2lab_lab_if;
  import rgb2lab_pkg::*;
  logic   valid;
  logic   ready;
  light_t lightness;
  axis_t  green_red_axis;
  axis_t  blue_yellow_axis;
  modport source (output valid, output lightness, output green_red_axis,
                  output blue_yellow_axis, input ready);
  modport sink (input valid, input lightness, input green_red_axis,
                input blue_yellow_axis, output ready);
endinterface

[design/rgb_to_cielab_converter.sv]
// Channel  | Direction | Contents
// pix_i    | in        | red_raw, green_raw, blue_raw (valid/ready)
// lab_o    | out       | lightness, green_red_axis, blue_yellow_axis (valid/ready)
// cfg      | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// One sample per cycle is accepted while the output is not stalled; the pipeline holds
// 40 register stages: the ratio divider (12 stages of two quotient bits), the matrix
// products and sums (2), the constant dividers (4), the cube root (21 stages of one result
// bit each, with the linear branch running alongside) and the output register (1).
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits and loads 1023 into all white references.
`include "rgb_to_cielab_converter_defines.svh"

module rgb_to_cielab_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgb2lab_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rgb2lab_pkg::CFG_W-1:0]       cfg_wdata_i,
  rgb2lab_pix_if.sink                         pix_i,
  rgb2lab_lab_if.source                       lab_o
);
  import rgb2lab_pkg::*;

  // Configuration registers.
  sample_t white_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) white_q[c] <= WHITE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WHITE_RED:   white_q[0] <= SAMPLE_BITS'(cfg_wdata_i);
        CFG_WHITE_GREEN: white_q[1] <= SAMPLE_BITS'(cfg_wdata_i);
        CFG_WHITE_BLUE:  white_q[2] <= SAMPLE_BITS'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  en;

  assign en          = !vld_q[PIPE_DEPTH-1] || lab_o.ready;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], pix_i.valid};
    end
  end

  // Ratio divider: restoring division of raw << 24 by the white reference.
  sample_t raw_in [NUM_CH];
  assign raw_in[0] = pix_i.red_raw;
  assign raw_in[1] = pix_i.green_raw;
  assign raw_in[2] = pix_i.blue_raw;

  sample_t          drem_q [DIV_STAGES][NUM_CH];
  sample_t          drem_d [DIV_STAGES][NUM_CH];
  logic [QUO_W-1:0] dquo_q [DIV_STAGES][NUM_CH];
  logic [QUO_W-1:0] dquo_d [DIV_STAGES][NUM_CH];
  logic             dsat_q [DIV_STAGES][NUM_CH];
  logic             dsat_d [DIV_STAGES][NUM_CH];

  function automatic logic [SAMPLE_BITS:0] div_step(input sample_t rem, input sample_t dvs);
    logic [SAMPLE_BITS:0] sh;
    sh = {rem, 1'b0};
    if (sh >= {1'b0, dvs}) return {1'b1, SAMPLE_BITS'(sh - {1'b0, dvs})};
    return {1'b0, sh[SAMPLE_BITS-1:0]};
  endfunction

  always_comb begin : div_comb
    sample_t              r;
    logic [QUO_W-1:0]     q;
    logic                 sf;
    logic [SAMPLE_BITS:0] st;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (s == 0) begin
          // A zero reference or a sample at or above it saturates to one.
          r  = raw_in[c];
          q  = '0;
          sf = (white_q[c] == '0) || (raw_in[c] >= white_q[c]);
        end else begin
          r  = drem_q[s-1][c];
          q  = dquo_q[s-1][c];
          sf = dsat_q[s-1][c];
        end
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
          st = div_step(r, white_q[c]);
          r  = st[SAMPLE_BITS-1:0];
          q  = {q[QUO_W-2:0], st[SAMPLE_BITS]};
        end
        drem_d[s][c] = r;
        dquo_d[s][c] = q;
        dsat_d[s][c] = sf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      drem_q <= drem_d;
      dquo_q <= dquo_d;
      dsat_q <= dsat_d;
    end
  end

  logic [RATIO_W-1:0] ratio [NUM_CH];
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ratio[c] = dsat_q[DIV_STAGES-1][c] ? RATIO_ONE : {1'b0, dquo_q[DIV_STAGES-1][c]};
    end
  end

  // Matrix products, then sums scaled for the white-point division.
  logic [PROD_W-1:0] prod_q [NUM_CH][NUM_CH];
  logic [CD_N_W-1:0] n2_q   [NUM_CH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < NUM_CH; r++) begin
        for (int k = 0; k < NUM_CH; k++) begin
          prod_q[r][k] <= PROD_W'(ratio[k]) * PROD_W'(MATRIX[r][k]);
        end
        n2_q[r] <= (CD_N_W'(prod_q[r][0]) + CD_N_W'(prod_q[r][1]) + CD_N_W'(prod_q[r][2]))
                   * CD_N_W'(T_MUL[r]) + CD_N_W'(T_ADD[r]);
      end
    end
  end

  // Constant dividers: reciprocal product gives a quotient at most one low,
  // and a single compare on the remainder fixes it.
  logic [CD_N_W-1:0]          cd_in    [CD_LANES];
  logic [CD_N_W-1:0]          nlin_q   [NUM_CH];
  logic [CD_HI_W+RECIP_W-1:0] cd1_ph_q [CD_LANES];
  logic [CD_SPLIT+RECIP_W-1:0] cd1_pl_q [CD_LANES];
  logic [CD_N_W-1:0]          cd1_n_q  [CD_LANES];
  logic [CD_Q_W-1:0]          cd2_q0_q [CD_LANES];
  logic [CD_N_W-1:0]          cd2_n_q  [CD_LANES];
  logic [CD_Q_W-1:0]          cd3_q0_q [CD_LANES];
  logic [CD_QD_W-1:0]         cd3_qd_q [CD_LANES];
  logic [CD_N_W-1:0]          cd3_n_q  [CD_LANES];
  logic [CD_Q_W-1:0]          cd4_q    [CD_LANES];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      cd_in[c]          = n2_q[c];
      cd_in[c + NUM_CH] = nlin_q[c];
    end
  end

  always_ff @(posedge clk_i) begin : cd_pipe
    logic [CD_N_W+RECIP_W:0] prod;
    logic [CD_QD_W-1:0]      rem;
    if (en) begin
      for (int l = 0; l < CD_LANES; l++) begin
        cd1_ph_q[l] <= (CD_HI_W+RECIP_W)'(cd_in[l][CD_N_W-1:CD_SPLIT])
                       * (CD_HI_W+RECIP_W)'(CD_RECIP[l]);
        cd1_pl_q[l] <= (CD_SPLIT+RECIP_W)'(cd_in[l][CD_SPLIT-1:0])
                       * (CD_SPLIT+RECIP_W)'(CD_RECIP[l]);
        cd1_n_q[l]  <= cd_in[l];

        prod = (CD_N_W+RECIP_W+1)'({cd1_ph_q[l], CD_SPLIT'(0)})
               + (CD_N_W+RECIP_W+1)'(cd1_pl_q[l]);
        cd2_q0_q[l] <= CD_Q_W'(prod >> CD_N_W);
        cd2_n_q[l]  <= cd1_n_q[l];

        cd3_qd_q[l] <= CD_QD_W'(cd2_q0_q[l]) * CD_QD_W'(CD_DIVISOR[l]);
        cd3_q0_q[l] <= cd2_q0_q[l];
        cd3_n_q[l]  <= cd2_n_q[l];

        rem = CD_QD_W'(cd3_n_q[l]) - cd3_qd_q[l];
        cd4_q[l] <= cd3_q0_q[l] + CD_Q_W'(rem >= CD_QD_W'(CD_DIVISOR[l]));
      end
    end
  end

  // Lab f: cube root one result bit per stage, keeping m, m^2 and m^3 so each
  // trial cube needs only shifts and adds.
  logic [T_W-1:0] t_val [NUM_CH];
  logic           t_cub [NUM_CH];
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      t_val[c] = cd4_q[c][T_W-1:0];
      t_cub[c] = (CD_N_W'(t_val[c]) * CD_N_W'(LIN_MUL)) > CUBE_LIMIT;
    end
  end

  logic [F_W-1:0]   cm_q   [CUBE_STEPS][NUM_CH];
  logic [F_W-1:0]   cm_d   [CUBE_STEPS][NUM_CH];
  logic [2*F_W-1:0] cm2_q  [CUBE_STEPS][NUM_CH];
  logic [2*F_W-1:0] cm2_d  [CUBE_STEPS][NUM_CH];
  logic [3*F_W-1:0] cm3_q  [CUBE_STEPS][NUM_CH];
  logic [3*F_W-1:0] cm3_d  [CUBE_STEPS][NUM_CH];
  logic [T_W-1:0]   ct_q   [CUBE_STEPS][NUM_CH];
  logic [T_W-1:0]   ct_d   [CUBE_STEPS][NUM_CH];
  logic             ccub_q [CUBE_STEPS][NUM_CH];
  logic             ccub_d [CUBE_STEPS][NUM_CH];

  always_comb begin : cube_comb
    logic [F_W-1:0]   m;
    logic [2*F_W-1:0] m2;
    logic [3*F_W-1:0] m3;
    logic [T_W-1:0]   tv;
    logic             cb;
    logic [63:0]      c2;
    logic [63:0]      c3;
    for (int j = 0; j < CUBE_STEPS; j++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (j == 0) begin
          m  = '0;
          m2 = '0;
          m3 = '0;
          tv = t_val[c];
          cb = t_cub[c];
        end else begin
          m  = cm_q[j-1][c];
          m2 = cm2_q[j-1][c];
          m3 = cm3_q[j-1][c];
          tv = ct_q[j-1][c];
          cb = ccub_q[j-1][c];
        end
        c3 = 64'(m3) + ((64'(m2) * 64'd3) << (CUBE_STEPS - 1 - j))
             + ((64'(m) * 64'd3) << (2 * (CUBE_STEPS - 1 - j)))
             + (64'd1 << (3 * (CUBE_STEPS - 1 - j)));
        c2 = 64'(m2) + (64'(m) << (CUBE_STEPS - j))
             + (64'd1 << (2 * (CUBE_STEPS - 1 - j)));
        if (c3 <= (64'(tv) << CUBE_SHIFT)) begin
          m  = m | (F_W'(1) << (CUBE_STEPS - 1 - j));
          m2 = (2*F_W)'(c2);
          m3 = (3*F_W)'(c3);
        end
        cm_d[j][c]   = m;
        cm2_d[j][c]  = m2;
        cm3_d[j][c]  = m3;
        ct_d[j][c]   = tv;
        ccub_d[j][c] = cb;
      end
    end
  end

  logic [F_W-1:0] lin_q [LIN_DEPTH][NUM_CH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cm_q   <= cm_d;
      cm2_q  <= cm2_d;
      cm3_q  <= cm3_d;
      ct_q   <= ct_d;
      ccub_q <= ccub_d;
      for (int c = 0; c < NUM_CH; c++) begin
        nlin_q[c]   <= CD_N_W'(t_val[c]) * CD_N_W'(LIN_MUL) + LIN_ADD;
        lin_q[0][c] <= cd4_q[c + NUM_CH][F_W-1:0];
        for (int k = 1; k < LIN_DEPTH; k++) lin_q[k][c] <= lin_q[k-1][c];
      end
    end
  end

  // Output stage: L*, a*, b* rounded half up to 4 fraction bits and saturated.
  logic signed [33:0] fs [NUM_CH];
  logic signed [33:0] l_n, a_n, b_n;
  logic signed [33:0] l_r, a_r, b_r;
  light_t             l_d;
  axis_t              a_d, b_d;
  light_t             l_q;
  axis_t              a_q, b_q;

  function automatic axis_t sat_axis(input logic signed [33:0] v);
    if (v < -34'sd2048) return axis_t'(-12'sd2048);
    if (v > 34'sd2047) return axis_t'(12'sd2047);
    return axis_t'(v);
  endfunction

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      fs[c] = signed'(34'(ccub_q[CUBE_STEPS-1][c] ? cm_q[CUBE_STEPS-1][c]
                                                  : lin_q[LIN_DEPTH-1][c]));
    end
    l_n = fs[1] * 34'sd116 - 34'sd16777216;
    a_n = (fs[0] - fs[1]) * 34'sd500;
    b_n = (fs[1] - fs[2]) * 34'sd200;
    l_r = (l_n + 34'sd32768) >>> 16;
    a_r = (a_n + 34'sd32768) >>> 16;
    b_r = (b_n + 34'sd32768) >>> 16;
    if (l_r < 34'sd0) begin
      l_d = '0;
    end else if (l_r > 34'sd2047) begin
      l_d = 11'd2047;
    end else begin
      l_d = light_t'(l_r);
    end
    a_d = sat_axis(a_r);
    b_d = sat_axis(b_r);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q <= l_d;
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign lab_o.valid            = vld_q[PIPE_DEPTH-1];
  assign lab_o.lightness        = l_q;
  assign lab_o.green_red_axis   = a_q;
  assign lab_o.blue_yellow_axis = b_q;

  `RGB2LAB_ASSERT_NEXT(a_stall_freezes_pipe, clk_i, rst_ni,
                       lab_o.valid && !lab_o.ready, $stable(vld_q))
  `RGB2LAB_ASSERT_IMPLIES(a_lin_branch_bound, clk_i, rst_ni,
                          vld_q[PIPE_DEPTH-2] && !ccub_q[CUBE_STEPS-1][1],
                          lin_q[LIN_DEPTH-1][1] < LIN_F_MAX)
  `RGB2LAB_ASSERT_IMPLIES(a_ready_when_out_empty, clk_i, rst_ni, !lab_o.valid, pix_i.ready)

endmodule
